// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge while out of reset.
`define AST_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define AST_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tber_pkg.sv
// Types and constants for the two-button event and auto-repeat detector.
package tber_pkg;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned NUM_BUTTONS = 2;
    localparam logic [CNT_W-1:0] REPEAT_INTERVAL_RESET = 16'd20;

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t        operation;
        logic [1:0] pin_levels;
    } in_word_t;

    typedef struct packed
    {
        logic b1_down;
        logic b1_up;
        logic b1_rpt;
        logic b2_down;
        logic b2_up;
        logic b2_rpt;
        logic both_down;
        logic none_down;
    } out_word_t;

endpackage

// File: src/two_button_event_repeat_top.sv
// Two-button press, release and auto-repeat detector, top level.
// A read word is held in the input stage register, and its result is then registered on out.
// Throughput: one word per cycle; a read waits while a stalled result is held.
// Reset: flags, levels and hold counters clear to zero;
// the repeat interval returns to 20 ticks.
`include "assert_macros.svh"

module two_button_event_repeat_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  tber_pkg::in_word_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output tber_pkg::out_word_t        out_data,
    input  logic                       cfg_wr_en,
    input  logic [tber_pkg::CNT_W-1:0] cfg_wr_data
);

    logic                       in_valid_reg;
    logic                       in_valid_next;
    tber_pkg::in_word_t         in_word_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    tber_pkg::out_word_t        out_word_reg;
    tber_pkg::out_word_t        out_word_next;
    logic [tber_pkg::CNT_W-1:0] interval_reg;

    logic [1:0]                 last_reg;
    logic [1:0]                 last_next;
    logic [1:0]                 press_reg;
    logic [1:0]                 press_next;
    logic [1:0]                 rel_reg;
    logic [1:0]                 rel_next;
    logic [1:0]                 rep_reg;
    logic [1:0]                 rep_next;
    logic [tber_pkg::NUM_BUTTONS-1:0][tber_pkg::CNT_W-1:0] cnt_reg;
    logic [tber_pkg::NUM_BUTTONS-1:0][tber_pkg::CNT_W-1:0] cnt_next;

    logic                       accept;
    logic                       advance;
    logic                       is_read;
    logic [1:0]                 down;

    assign is_read  = (in_word_reg.operation == tber_pkg::OP_READ);
    assign advance  = in_valid_reg && (!is_read || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign down     = ~in_word_reg.pin_levels;

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // input stage and result handshake
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && is_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // flag and counter update
    always_comb
    begin
        last_next     = last_reg;
        press_next    = press_reg;
        rel_next      = rel_reg;
        rep_next      = rep_reg;
        cnt_next      = cnt_reg;
        out_word_next = out_word_reg;
        if (advance)
        begin
            unique case (in_word_reg.operation)
                tber_pkg::OP_TICK:
                begin
                    press_next = press_reg | (down & ~last_reg);
                    rel_next   = rel_reg | (~down & last_reg);
                    last_next  = down;
                    for (int i = 0; i < tber_pkg::NUM_BUTTONS; i++)
                    begin
                        if (press_next[i])
                        begin
                            if (rel_next[i])
                            begin
                                cnt_next[i] = '0;
                            end
                            else if (cnt_reg[i] >= interval_reg)
                            begin
                                rep_next[i] = 1'b1;
                                cnt_next[i] = tber_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                cnt_next[i] = cnt_reg[i] + tber_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
                tber_pkg::OP_READ:
                begin
                    out_word_next.b1_down = press_reg[0];
                    out_word_next.b1_up   = rel_reg[0];
                    out_word_next.b1_rpt  = rep_reg[0];
                    out_word_next.b2_down = press_reg[1];
                    out_word_next.b2_up   = rel_reg[1];
                    out_word_next.b2_rpt  = rep_reg[1];
                    // acknowledge released buttons
                    for (int i = 0; i < tber_pkg::NUM_BUTTONS; i++)
                    begin
                        if (rel_reg[i])
                        begin
                            press_next[i] = 1'b0;
                            rel_next[i]   = 1'b0;
                            rep_next[i]   = 1'b0;
                            cnt_next[i]   = '0;
                        end
                    end
                    out_word_next.both_down = &press_next;
                    out_word_next.none_down = ~|last_reg;
                end
                default:
                begin
                    last_next = last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            interval_reg  <= tber_pkg::REPEAT_INTERVAL_RESET;
            last_reg      <= '0;
            press_reg     <= '0;
            rel_reg       <= '0;
            rep_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
            last_reg  <= last_next;
            press_reg <= press_next;
            rel_reg   <= rel_next;
            rep_reg   <= rep_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= in_data;
        end
        out_word_reg <= out_word_next;
    end

    `AST_CLK(a_out_hold, (out_valid_reg && out_stall |=> out_valid_reg && $stable(out_word_reg)), "stalled result changed")
    `AST_CLK(a_rep_has_press, ((rep_reg & ~press_reg) == 2'b00), "repeat flag without press flag")
    `AST_CLK(a_cnt_idle_zero, ((cnt_reg[0] == '0 || (press_reg[0] && !rel_reg[0])) && (cnt_reg[1] == '0 || (press_reg[1] && !rel_reg[1]))), "hold counter running while not held")
    `AST_CLK_ALWAYS(a_read_result, (rst_n && advance && is_read |=> out_valid_reg), "read word gave no result")

endmodule
